// ===== rtl/slnw_pkg.sv =====
package slnw_pkg;

  // field widths
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 3;
  localparam int unsigned NumW  = 17;

  // command codes
  localparam logic [CmdW-1:0] CMD_INSTR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_DATA   = 2'd1;
  localparam logic [CmdW-1:0] CMD_NUMBER = 2'd2;
  // the one code with no use, ignored by the block
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  // frame constants
  localparam logic [ByteW-1:0] SYNC_INSTR = 8'hF8;
  localparam logic [ByteW-1:0] SYNC_DATA  = 8'hFA;
  localparam logic [3:0]       ASCII_HI   = 4'h3;

  // step addresses of the control store
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] ST_IDLE   = 4'd0;
  localparam logic [StepW-1:0] ST_F_SYNC = 4'd1;
  localparam logic [StepW-1:0] ST_F_HI   = 4'd2;
  localparam logic [StepW-1:0] ST_F_LO   = 4'd3;
  localparam logic [StepW-1:0] ST_DIV    = 4'd4;
  localparam logic [StepW-1:0] ST_POSCHK = 4'd5;
  localparam logic [StepW-1:0] ST_P_SYNC = 4'd6;
  localparam logic [StepW-1:0] ST_P_HI   = 4'd7;
  localparam logic [StepW-1:0] ST_P_LO   = 4'd8;
  localparam logic [StepW-1:0] ST_D_SYNC = 4'd9;
  localparam logic [StepW-1:0] ST_D_HI   = 4'd10;
  localparam logic [StepW-1:0] ST_D_LO   = 4'd11;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_SYNC_REG,
    EM_SYNC_I,
    EM_SYNC_D,
    EM_HI,
    EM_LO
  } emit_e;

  typedef enum logic [1:0] {
    LAST_NONE,
    LAST_ONE,
    LAST_IDX0
  } last_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DISPATCH,
    ACT_DIV,
    ACT_LOAD_POS,
    ACT_LOAD_DIG,
    ACT_DEC_IDX
  } act_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_DIV_MORE,
    JC_NO_POS,
    JC_MORE_DIG
  } jump_e;

  typedef struct packed {
    emit_e            emit;
    last_e            last;
    act_e             act;
    jump_e            jump;
    logic [StepW-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic div_more;
    logic no_pos;
    logic more_dig;
  } stat_t;

endpackage

// ===== rtl/slnw_seq.sv =====
module slnw_seq import slnw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [CmdW-1:0] command_i,
  input  stat_t           stat_i,
  input  logic            out_free_i,
  output ctl_t            ctl_o,
  output logic            adv_o,
  output logic            in_ready_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] step_inc;

  function automatic ctl_t rom_word(input logic [StepW-1:0] a);
    ctl_t w;
    w = '{emit: EM_NONE, last: LAST_NONE, act: ACT_NONE, jump: JC_ALWAYS, target: ST_IDLE};
    case (a)
      ST_IDLE: begin
        w.act  = ACT_DISPATCH;
        w.jump = JC_DISPATCH;
      end
      ST_F_SYNC: begin
        w.emit = EM_SYNC_REG;
        w.jump = JC_NEXT;
      end
      ST_F_HI: begin
        w.emit = EM_HI;
        w.jump = JC_NEXT;
      end
      ST_F_LO: begin
        w.emit = EM_LO;
        w.last = LAST_ONE;
      end
      ST_DIV: begin
        w.act    = ACT_DIV;
        w.jump   = JC_DIV_MORE;
        w.target = ST_DIV;
      end
      ST_POSCHK: begin
        w.jump   = JC_NO_POS;
        w.target = ST_D_SYNC;
      end
      ST_P_SYNC: begin
        w.emit = EM_SYNC_I;
        w.act  = ACT_LOAD_POS;
        w.jump = JC_NEXT;
      end
      ST_P_HI: begin
        w.emit = EM_HI;
        w.jump = JC_NEXT;
      end
      ST_P_LO: begin
        w.emit = EM_LO;
        w.jump = JC_NEXT;
      end
      ST_D_SYNC: begin
        w.emit = EM_SYNC_D;
        w.act  = ACT_LOAD_DIG;
        w.jump = JC_NEXT;
      end
      ST_D_HI: begin
        w.emit = EM_HI;
        w.jump = JC_NEXT;
      end
      ST_D_LO: begin
        w.emit   = EM_LO;
        w.last   = LAST_IDX0;
        w.act    = ACT_DEC_IDX;
        w.jump   = JC_MORE_DIG;
        w.target = ST_D_SYNC;
      end
      default: begin
        w.jump = JC_ALWAYS;
      end
    endcase
    return w;
  endfunction

  assign ctl_o      = rom_word(step_q);
  assign in_ready_o = (step_q == ST_IDLE);
  assign step_inc   = step_q + StepW'(1);

  // waits: idle for input, emit steps for room in the output register
  always_comb begin
    if (step_q == ST_IDLE) begin
      adv_o = in_valid_i;
    end else if (ctl_o.emit != EM_NONE) begin
      adv_o = out_free_i;
    end else begin
      adv_o = 1'b1;
    end
  end

  always_comb begin
    step_d = step_q;
    case (ctl_o.jump)
      JC_NEXT:     step_d = step_inc;
      JC_ALWAYS:   step_d = ctl_o.target;
      JC_DISPATCH: begin
        case (command_i)
          CMD_INSTR:  step_d = ST_F_SYNC;
          CMD_DATA:   step_d = ST_F_SYNC;
          CMD_NUMBER: step_d = ST_DIV;
          default:    step_d = ST_IDLE;
        endcase
      end
      JC_DIV_MORE: step_d = stat_i.div_more ? ctl_o.target : step_inc;
      JC_NO_POS:   step_d = stat_i.no_pos ? ctl_o.target : step_inc;
      JC_MORE_DIG: step_d = stat_i.more_dig ? ctl_o.target : ST_IDLE;
      default:     step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else if (adv_o) begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/slnw_dp.sv =====
module slnw_dp import slnw_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  input  logic             adv_i,
  input  logic [CmdW-1:0]  command_i,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic [PosW-1:0]  row_i,
  input  logic [PosW-1:0]  column_i,
  input  logic [NumW-1:0]  number_i,
  input  logic             out_ready_i,
  output stat_t            stat_o,
  output logic             out_free_o,
  output logic             out_valid_o,
  output logic [ByteW-1:0] serial_byte_o,
  output logic             last_o
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam int unsigned MulW = 2 * NumW;
  // floor(n / 10) == (n * Recip10) >> Shift10 for every n below 2^18
  localparam logic [NumW-1:0] Recip10 = 17'd104858;
  localparam int unsigned     Shift10 = 20;

  function automatic logic [63:0] pow10_less1(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

  localparam logic [63:0] NumLimit = pow10_less1(MAX_DIGITS);

  logic [ByteW-1:0] cur_q;
  logic             sync_data_q;
  logic [NumW-1:0]  num_q;
  logic [PosW-1:0]  row_q;
  logic [PosW-1:0]  col_q;
  logic [IdxW-1:0]  k_q;
  logic [IdxW-1:0]  idx_q;
  logic [3:0]       dig_q [MAX_DIGITS];

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  logic [NumW-1:0]  num_sat;
  logic [MulW-1:0]  prod;
  logic [NumW-1:0]  quot;
  logic [NumW-1:0]  quot10;
  logic [NumW-1:0]  rem_full;
  logic [3:0]       rem;
  logic [ByteW-1:0] pos_base;
  logic [ByteW-1:0] emit_byte;
  logic             emit_last;
  logic             do_emit;

  assign num_sat = ({47'd0, number_i} > NumLimit) ? NumLimit[NumW-1:0] : number_i;

  assign prod     = MulW'(num_q) * MulW'(Recip10);
  assign quot     = NumW'(prod >> Shift10);
  assign quot10   = (quot << 3) + (quot << 1);
  assign rem_full = num_q - quot10;
  assign rem      = rem_full[3:0];

  always_comb begin
    case (row_q)
      3'd1:    pos_base = 8'h80;
      3'd2:    pos_base = 8'h90;
      3'd3:    pos_base = 8'h88;
      3'd4:    pos_base = 8'h98;
      default: pos_base = 8'h00;
    endcase
  end

  assign stat_o.div_more = (k_q != IdxW'(MAX_DIGITS - 1));
  assign stat_o.no_pos   = !(row_q inside {[3'd1 : 3'd4]});
  assign stat_o.more_dig = (idx_q != '0);

  always_comb begin
    case (ctl_i.emit)
      EM_SYNC_REG: emit_byte = sync_data_q ? SYNC_DATA : SYNC_INSTR;
      EM_SYNC_I:   emit_byte = SYNC_INSTR;
      EM_SYNC_D:   emit_byte = SYNC_DATA;
      EM_HI:       emit_byte = {cur_q[7:4], 4'h0};
      EM_LO:       emit_byte = {cur_q[3:0], 4'h0};
      default:     emit_byte = '0;
    endcase
  end

  always_comb begin
    case (ctl_i.last)
      LAST_ONE:  emit_last = 1'b1;
      LAST_IDX0: emit_last = (idx_q == '0);
      default:   emit_last = 1'b0;
    endcase
  end

  assign out_free_o = !out_valid_q || out_ready_i;
  assign do_emit    = adv_i && (ctl_i.emit != EM_NONE);

  // working registers
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      case (ctl_i.act)
        ACT_DISPATCH: begin
          cur_q       <= byte_value_i;
          sync_data_q <= (command_i == CMD_DATA);
          num_q       <= num_sat;
          row_q       <= row_i;
          col_q       <= column_i;
          k_q         <= '0;
          idx_q       <= IdxW'(1);
        end
        ACT_DIV: begin
          num_q <= quot;
          k_q   <= k_q + IdxW'(1);
          if (rem != 4'd0 && k_q != '0) begin
            idx_q <= k_q;
          end
        end
        ACT_LOAD_POS: cur_q <= pos_base | {5'd0, col_q};
        ACT_LOAD_DIG: cur_q <= {ASCII_HI, dig_q[idx_q]};
        ACT_DEC_IDX:  idx_q <= idx_q - IdxW'(1);
        default: ;
      endcase
    end
  end

  // digit shift line, least significant digit ends at index 0
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_dig
    always_ff @(posedge clk_i) begin
      if (adv_i && ctl_i.act == ACT_DIV) begin
        if (g == MAX_DIGITS - 1) begin
          dig_q[g] <= rem;
        end else begin
          dig_q[g] <= dig_q[(g + 1) % MAX_DIGITS];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign serial_byte_o = out_byte_q;
  assign last_o        = out_last_q;

endmodule

// ===== rtl/serial_lcd_number_writer_top.sv =====
// instruction or data byte: accept, then emit sync, high and low frame bytes
// number: accept, divide loop, position check, position frame if row is 1 to 4, digit frames
// the first byte is registered at the first emit step, after the divide loop for a number
// step loop rate: one digit per cycle, one frame byte per cycle while the output has room
// a stalled output holds the sequencer on its emit step
// reset (rst_ni low, async) returns the step counter to idle and drops out_valid_o
module serial_lcd_number_writer_top import slnw_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CmdW-1:0]  command_i,
  input  logic [ByteW-1:0] byte_value_i,
  input  logic [PosW-1:0]  row_i,
  input  logic [PosW-1:0]  column_i,
  input  logic [NumW-1:0]  number_i,
  // serial byte channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] serial_byte_o,
  output logic             last_o
);

  // control word of the current step and status fed back for jumps
  ctl_t  ctl;
  stat_t stat;
  // step advances this cycle (input transfer in idle, room for an emit, else always)
  logic  adv;
  logic  out_free;

  // step counter plus control store: dispatch, digit loop, frame emit loops
  slnw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .stat_i     (stat),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .adv_o      (adv),
    .in_ready_o (in_ready_o)
  );

  // datapath: saturate, split into digits by reciprocal multiply,
  // build position byte and ascii digits, frame into sync/high/low bytes
  slnw_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .adv_i         (adv),
    .command_i     (command_i),
    .byte_value_i  (byte_value_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .number_i      (number_i),
    .out_ready_i   (out_ready_i),
    .stat_o        (stat),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .serial_byte_o (serial_byte_o),
    .last_o        (last_o)
  );

endmodule

// ===== rtl/slnw_checker.sv =====
module slnw_checker import slnw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [CmdW-1:0]  command_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] serial_byte_o,
  input logic             last_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // a stalled result keeps its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(serial_byte_o) && $stable(last_o))
    else $error("stalled output changed");

  // a command that produces bytes closes the input until its run ends
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && command_i != CMD_UNUSED |=> !in_ready_o)
    else $error("input reopened during a run");

  // the unused command produces nothing and leaves the input open
  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && command_i == CMD_UNUSED |=> in_ready_o)
    else $error("unused command started a run");

  // a byte that is not the last one belongs to a run still in progress
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open while a run is unfinished");

endmodule

bind serial_lcd_number_writer_top slnw_checker u_slnw_checker (.*);

// ===== test/serial_lcd_number_writer_top_tb.sv =====
`timescale 1ns / 1ps

module serial_lcd_number_writer_top_tb;
  import slnw_pkg::*;

  localparam int unsigned DIGITS = 5;

  typedef struct {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] byte_value;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  column;
    logic [NumW-1:0]  number;
  } lcd_cmd_t;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } link_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CmdW-1:0]  command = '0;
  logic [ByteW-1:0] byte_value = '0;
  logic [PosW-1:0]  row = '0;
  logic [PosW-1:0]  column = '0;
  logic [NumW-1:0]  number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] serial_byte;
  logic             last;

  // commands waiting to be offered, and link bytes the block still owes us
  lcd_cmd_t   cmd_backlog[$];
  link_byte_t bytes_owed[$];

  int       mismatches = 0;
  int       cmds_taken = 0;
  int       send_gap = 0;
  int       sink_gap = 0;
  logic     cmd_taken = 1'b0;
  logic     hold_off = 1'b0;
  logic     calm;
  lcd_cmd_t next_cmd;

  serial_lcd_number_writer_top #(
    .MAX_DIGITS(DIGITS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .byte_value_i (byte_value),
    .row_i        (row),
    .column_i     (column),
    .number_i     (number),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .serial_byte_o(serial_byte),
    .last_o       (last)
  );

  always #5 clk = ~clk;

  // near the end of the stimulus neither side idles any more
  assign calm = (cmd_backlog.size() < 20);

  // one lcd byte goes out as sync, high nibble, low nibble moved up
  task automatic owe_frame(input logic [ByteW-1:0] sync, input logic [ByteW-1:0] b);
    bytes_owed.push_back('{data: sync, last: 1'b0});
    bytes_owed.push_back('{data: {b[7:4], 4'h0}, last: 1'b0});
    bytes_owed.push_back('{data: {b[3:0], 4'h0}, last: 1'b0});
  endtask

  // expand one command into the link bytes it should produce
  task automatic frame_command(input lcd_cmd_t c);
    int               start;
    int               lead;
    int               limit;
    int               val;
    logic [3:0]       dig[DIGITS];
    logic [ByteW-1:0] pos_base;
    logic             positioned;
    start = bytes_owed.size();
    case (c.command)
      CMD_INSTR: begin
        owe_frame(SYNC_INSTR, c.byte_value);
      end
      CMD_DATA: begin
        owe_frame(SYNC_DATA, c.byte_value);
      end
      CMD_NUMBER: begin
        positioned = 1'b1;
        pos_base = 8'h00;
        case (c.row)
          3'd1: pos_base = 8'h80;
          3'd2: pos_base = 8'h90;
          3'd3: pos_base = 8'h88;
          3'd4: pos_base = 8'h98;
          default: positioned = 1'b0;
        endcase
        if (positioned) begin
          owe_frame(SYNC_INSTR, pos_base | {5'd0, c.column});
        end
        // saturate to the widest value that fits the digit count
        limit = 1;
        for (int k = 0; k < DIGITS; k++) limit = limit * 10;
        val = int'(c.number);
        if (val > limit - 1) val = limit - 1;
        for (int k = DIGITS - 1; k >= 0; k--) begin
          dig[k] = 4'(val % 10);
          val = val / 10;
        end
        // drop leading zeros but always print at least two digits
        lead = 0;
        while (lead < DIGITS && dig[lead] == 4'd0) lead++;
        if (lead == DIGITS) lead = DIGITS - 1;
        if (lead == DIGITS - 1) owe_frame(SYNC_DATA, {ASCII_HI, 4'h0});
        for (int k = lead; k < DIGITS; k++) owe_frame(SYNC_DATA, {ASCII_HI, dig[k]});
      end
      default: ;
    endcase
    if (bytes_owed.size() > start) bytes_owed[bytes_owed.size() - 1].last = 1'b1;
  endtask

  task automatic queue_cmd(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] bval,
                           input logic [PosW-1:0] r, input logic [PosW-1:0] col,
                           input logic [NumW-1:0] num);
    cmd_backlog.push_back('{command: cmd, byte_value: bval, row: r, column: col,
                            number: num});
  endtask

  // command driver: new values at the falling edge, held until the transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !cmd_taken) begin
      // still waiting for the transfer, payload held
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (cmd_backlog.size() > 0 && (calm || $urandom_range(0, 7) != 0)) begin
      next_cmd = cmd_backlog.pop_front();
      command <= next_cmd.command;
      byte_value <= next_cmd.byte_value;
      row <= next_cmd.row;
      column <= next_cmd.column;
      number <= next_cmd.number;
      in_valid <= 1'b1;
    end else if (cmd_backlog.size() > 0) begin
      // idle burst
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 14);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // byte sink: random stall bursts, plus the long hold-off below
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      sink_gap <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sample both channels at the rising edge; predict before checking
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        frame_command('{command: command, byte_value: byte_value, row: row,
                        column: column, number: number});
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        if (bytes_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte %02h last %0b", $time, serial_byte, last);
        end else begin
          link_byte_t want;
          want = bytes_owed.pop_front();
          if (serial_byte !== want.data || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                       $time, want.data, want.last, serial_byte, last);
          end
        end
      end
    end
  end

  // long sink hold-off so the block backs up and drops in_ready
  initial begin
    while (!rst_n || cmds_taken < 40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("serial_lcd_number_writer_top regression: fail");
    $finish;
  end

  initial begin
    int       counted;
    int       pick;
    int       span;
    lcd_cmd_t c;

    // directed: byte extremes, every command, each position row, number corner cases
    queue_cmd(CMD_INSTR, 8'h00, 3'd7, 3'd7, 17'h1ffff);
    queue_cmd(CMD_INSTR, 8'hff, 3'd0, 3'd0, 17'd0);
    queue_cmd(CMD_DATA, 8'h00, 3'd5, 3'd2, 17'd12);
    queue_cmd(CMD_DATA, 8'hff, 3'd1, 3'd7, 17'd99999);
    queue_cmd(CMD_DATA, 8'h5a, 3'd0, 3'd0, 17'd0);
    queue_cmd(CMD_UNUSED, 8'ha5, 3'd1, 3'd3, 17'd42);       // ignored command
    queue_cmd(CMD_NUMBER, 8'h00, 3'd1, 3'd0, 17'd0);        // zero pads to two digits
    queue_cmd(CMD_NUMBER, 8'hff, 3'd2, 3'd7, 17'd9);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd3, 3'd5, 17'd10);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd4, 3'd1, 17'd99);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd0, 3'd7, 17'd100);      // no positioning
    queue_cmd(CMD_NUMBER, 8'h00, 3'd5, 3'd4, 17'd10203);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd6, 3'd6, 17'd10000);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd7, 3'd0, 17'd99999);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd1, 3'd7, 17'd100000);   // saturates
    queue_cmd(CMD_NUMBER, 8'hff, 3'd4, 3'd7, 17'h1ffff);    // saturates, all bits set
    queue_cmd(CMD_UNUSED, 8'h00, 3'd0, 3'd0, 17'd0);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd2, 3'd0, 17'd1000);
    queue_cmd(CMD_INSTR, 8'ha5, 3'd2, 3'd1, 17'd5);
    queue_cmd(CMD_NUMBER, 8'h00, 3'd3, 3'd3, 17'd7);

    // random mix, numbers weighted toward every digit count
    counted = 0;
    while (counted < 110) begin
      pick = $urandom_range(0, 99);
      c.byte_value = 8'($urandom_range(0, 255));
      c.row = 3'($urandom_range(0, 7));
      c.column = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: span = 9;
        1: span = 99;
        2: span = 999;
        3: span = 9999;
        4: span = 99999;
        default: span = 131071;
      endcase
      c.number = 17'($urandom_range(0, span));
      if (pick < 4) begin
        c.command = CMD_UNUSED;
      end else begin
        if (pick < 18) c.command = CMD_INSTR;
        else if (pick < 32) c.command = CMD_DATA;
        else c.command = CMD_NUMBER;
        counted++;
      end
      cmd_backlog.push_back(c);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || in_valid) @(posedge clk);
    while (bytes_owed.size() > 0) @(posedge clk);
    // give a stray extra byte time to show up
    repeat (40) @(posedge clk);

    if (bytes_owed.size() > 0) begin
      mismatches++;
      $display("%0d expected bytes never arrived", bytes_owed.size());
    end
    if (mismatches == 0) begin
      $display("serial_lcd_number_writer_top regression: pass");
    end else begin
      $display("serial_lcd_number_writer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/slnw_pkg.sv
rtl/slnw_seq.sv
rtl/slnw_dp.sv
rtl/serial_lcd_number_writer_top.sv
rtl/slnw_checker.sv
test/serial_lcd_number_writer_top_tb.sv
